[rtl/mrtc_pkg.sv]
// ----------------------------------------------------------------------------
// mrtc_pkg: shared types and constants for the millisecond RTC
// Item kinds, set-time scale factors and the sideband records that travel
// alongside the decode pipeline.
// ----------------------------------------------------------------------------
package mrtc_pkg;

  localparam int unsigned TICKS_PER_SECOND_DEF = 1000;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned HOURS_W = 11;
  localparam int unsigned MINS_W  = 6;
  localparam int unsigned SECS_W  = 6;
  localparam int unsigned MILLI_W = 10;

  // set time always scales in milliseconds, whatever the tick rate
  localparam logic [CNT_W-1:0] MS_PER_SEC  = 32'd1000;
  localparam logic [CNT_W-1:0] MS_PER_MIN  = 32'd60000;
  localparam logic [CNT_W-1:0] MS_PER_HOUR = 32'd3600000;

  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned MINS_PER_HOUR = 60;

  typedef enum logic [2:0] {
    KIND_TICK = 3'd0,
    KIND_SET  = 3'd1,
    KIND_ARM  = 3'd2,
    KIND_STOP = 3'd3,
    KIND_MARK = 3'd4
  } kind_t;

  typedef struct packed {
    logic [CNT_W-1:0] tick_now;
    logic [CNT_W-1:0] elapsed;
    logic             due;
    logic             armed;
  } stat_t;

  typedef struct packed {
    stat_t              stat;
    logic [HOURS_W-1:0] hours;
  } hstat_t;

  typedef struct packed {
    stat_t              stat;
    logic [HOURS_W-1:0] hours;
    logic [MINS_W-1:0]  minutes;
  } hmstat_t;

endpackage

[rtl/millisecond_rtc_with_alarm.sv]
// One item per cycle unless result_stall holds; a waiting result does not
// block new items while the 12-stage pipeline has empty stages.
// Reset clears the counter, context mark, alarm time and alarm enable to zero
// and empties the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
// millisecond_rtc_with_alarm: 32-bit tick counter with alarm and time decode
// State core followed by three constant dividers (hour, minute, second).
// ----------------------------------------------------------------------------
module millisecond_rtc_with_alarm #(
  parameter int unsigned TICKS_PER_SECOND = mrtc_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  kind,
  input  logic [10:0] set_hours,
  input  logic [5:0]  set_minutes,
  input  logic [5:0]  set_seconds,
  input  logic [9:0]  set_millis,
  input  logic [31:0] alarm_timeout,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] tick_now,
  output logic [31:0] elapsed_ticks,
  output logic [10:0] hours_now,
  output logic [5:0]  minutes_now,
  output logic [5:0]  seconds_now,
  output logic [9:0]  millis_now,
  output logic        alarm_due,
  output logic        alarm_armed
);

  import mrtc_pkg::*;

  localparam longint unsigned TPM_L = longint'(TICKS_PER_SECOND) * SECS_PER_MIN;
  localparam longint unsigned TPH_L = TPM_L * MINS_PER_HOUR;
  localparam logic [CNT_W-1:0] TPS  = CNT_W'(TICKS_PER_SECOND);
  localparam logic [CNT_W-1:0] TPM  = CNT_W'(TPM_L);
  localparam logic [CNT_W-1:0] TPH  = CNT_W'(TPH_L);

  logic             c_valid, c_stall;
  stat_t            c_stat;
  logic             h_valid, h_stall;
  stat_t            h_side;
  logic [CNT_W-1:0] h_q, h_r;
  hstat_t           m_in;
  logic             m_valid, m_stall;
  hstat_t           m_side;
  logic [CNT_W-1:0] m_q, m_r;
  hmstat_t          s_in;
  hmstat_t          s_side;
  logic [CNT_W-1:0] s_q, s_r;

  mrtc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .kind          (kind),
    .set_hours     (set_hours),
    .set_minutes   (set_minutes),
    .set_seconds   (set_seconds),
    .set_millis    (set_millis),
    .alarm_timeout (alarm_timeout),
    .res_valid     (c_valid),
    .res_stall     (c_stall),
    .res_stat      (c_stat)
  );

  // counter / ticks per hour
  mrtc_cdiv #(
    .W       (CNT_W),
    .DIVISOR (TPH),
    .SIDE_W  ($bits(stat_t))
  ) u_div_hour (
    .clk       (clk),
    .rst       (rst),
    .src_valid (c_valid),
    .src_stall (c_stall),
    .x         (c_stat.tick_now),
    .side      (c_stat),
    .dst_valid (h_valid),
    .dst_stall (h_stall),
    .q         (h_q),
    .r         (h_r),
    .dst_side  (h_side)
  );

  assign m_in.stat  = h_side;
  assign m_in.hours = h_q[HOURS_W-1:0];

  // remainder within the hour / ticks per minute
  mrtc_cdiv #(
    .W       (CNT_W),
    .DIVISOR (TPM),
    .SIDE_W  ($bits(hstat_t))
  ) u_div_min (
    .clk       (clk),
    .rst       (rst),
    .src_valid (h_valid),
    .src_stall (h_stall),
    .x         (h_r),
    .side      (m_in),
    .dst_valid (m_valid),
    .dst_stall (m_stall),
    .q         (m_q),
    .r         (m_r),
    .dst_side  (m_side)
  );

  assign s_in.stat    = m_side.stat;
  assign s_in.hours   = m_side.hours;
  assign s_in.minutes = m_q[MINS_W-1:0];

  // remainder within the minute / ticks per second; last stage is the result
  mrtc_cdiv #(
    .W       (CNT_W),
    .DIVISOR (TPS),
    .SIDE_W  ($bits(hmstat_t))
  ) u_div_sec (
    .clk       (clk),
    .rst       (rst),
    .src_valid (m_valid),
    .src_stall (m_stall),
    .x         (m_r),
    .side      (s_in),
    .dst_valid (result_valid),
    .dst_stall (result_stall),
    .q         (s_q),
    .r         (s_r),
    .dst_side  (s_side)
  );

  assign tick_now      = s_side.stat.tick_now;
  assign elapsed_ticks = s_side.stat.elapsed;
  assign hours_now     = s_side.hours;
  assign minutes_now   = s_side.minutes;
  assign seconds_now   = s_q[SECS_W-1:0];
  assign millis_now    = s_r[MILLI_W-1:0];
  assign alarm_due     = s_side.stat.due;
  assign alarm_armed   = s_side.stat.armed;

endmodule

[rtl/mrtc_cdiv.sv]
// ----------------------------------------------------------------------------
// mrtc_cdiv: pipelined divide by a constant
// Reciprocal multiply, back-multiply, then one compare-and-subtract fix-up.
// Three register stages, one transfer per cycle when not stalled, bubbles collapse on stall.
// ----------------------------------------------------------------------------
module mrtc_cdiv #(
  parameter int unsigned     W       = 32,
  parameter logic [W-1:0]    DIVISOR = 1,
  parameter int unsigned     SIDE_W  = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  logic [W-1:0]      x,
  input  logic [SIDE_W-1:0] side,
  output logic              dst_valid,
  input  logic              dst_stall,
  output logic [W-1:0]      q,
  output logic [W-1:0]      r,
  output logic [SIDE_W-1:0] dst_side
);

  // K = floor(log2 DIVISOR); reciprocal scaled so the estimate is q or q-1
  localparam int unsigned      K     = $clog2(64'(DIVISOR) + 64'd1) - 1;
  localparam logic [2*W:0]     SCALE = (2*W+1)'(1) << (W + K);
  localparam logic [2*W:0]     MFULL = SCALE / (2*W+1)'(DIVISOR);
  localparam logic [2*W:0]     MMAX  = (2*W+1)'({W{1'b1}});
  localparam logic [W-1:0]     MUL   = (MFULL > MMAX) ? {W{1'b1}} : MFULL[W-1:0];

  logic              v1, v2, v3;
  logic              rdy1, rdy2, rdy3;
  logic [W-1:0]      x1, x2;
  logic [SIDE_W-1:0] side1, side2;
  logic [2*W-1:0]    p1;
  logic [W-1:0]      q2, qd2;
  logic [W-1:0]      q_est, qd_c, r_est;
  logic              fix;

  assign rdy3      = !v3 || !dst_stall;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign src_stall = !rdy1;
  assign dst_valid = v3;

  assign q_est = W'(p1 >> (W + K));
  assign qd_c  = q_est * DIVISOR;
  assign r_est = x2 - qd2;
  assign fix   = (r_est >= DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= src_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1    <= x;
      side1 <= side;
      p1    <= (2*W)'(x) * (2*W)'(MUL);
    end
    if (rdy2) begin
      x2    <= x1;
      side2 <= side1;
      q2    <= q_est;
      qd2   <= qd_c;
    end
    if (rdy3) begin
      dst_side <= side2;
      q        <= fix ? q2 + W'(1) : q2;
      r        <= fix ? r_est - DIVISOR : r_est;
    end
  end

endmodule

[rtl/mrtc_core.sv]
// ----------------------------------------------------------------------------
// mrtc_core: counter, context mark and alarm state
// Registers the item, applies it to the state, then forms the counter,
// elapsed count and alarm flags for the decode pipeline.
// ----------------------------------------------------------------------------
module mrtc_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [2:0]               kind,
  input  logic [10:0]              set_hours,
  input  logic [5:0]               set_minutes,
  input  logic [5:0]               set_seconds,
  input  logic [9:0]               set_millis,
  input  logic [31:0]              alarm_timeout,
  output logic                     res_valid,
  input  logic                     res_stall,
  output mrtc_pkg::stat_t          res_stat
);

  import mrtc_pkg::*;

  logic             va, vb, vc;
  logic             rdya, rdyb, rdyc;
  logic             fire;
  kind_t            kind_a;
  logic [CNT_W-1:0] tmo_a, set_a, set_c;

  logic [CNT_W-1:0] counter, mark, alarm_time;
  logic             alarm_active;
  logic [CNT_W-1:0] counter_next, mark_next, alarm_time_next, inc;
  logic             alarm_active_next, due_next;

  logic [CNT_W-1:0] cnt_b, mark_b;
  logic             due_b, armed_b;

  assign rdyc       = !vc || !res_stall;
  assign rdyb       = !vb || rdyc;
  assign rdya       = !va || rdyb;
  assign item_stall = !rdya;
  assign res_valid  = vc;
  assign fire       = va && rdyb;

  // set value wraps at 32 bits, fields taken at full width
  assign set_c = CNT_W'(set_millis)
               + CNT_W'(set_seconds) * MS_PER_SEC
               + CNT_W'(set_minutes) * MS_PER_MIN
               + CNT_W'(set_hours)   * MS_PER_HOUR;

  assign inc = counter + CNT_W'(1);

  always_comb begin
    counter_next      = counter;
    mark_next         = mark;
    alarm_time_next   = alarm_time;
    alarm_active_next = alarm_active;
    due_next          = 1'b0;
    case (kind_a)
      KIND_TICK: begin
        counter_next = inc;
        due_next     = alarm_active && (alarm_time <= inc);
      end
      KIND_SET: begin
        counter_next = set_a;
        mark_next    = set_a;
      end
      KIND_ARM: begin
        alarm_time_next   = counter + tmo_a;
        alarm_active_next = 1'b1;
      end
      KIND_STOP: begin
        alarm_time_next   = '0;
        alarm_active_next = 1'b0;
      end
      KIND_MARK: begin
        mark_next = counter;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va           <= 1'b0;
      vb           <= 1'b0;
      vc           <= 1'b0;
      counter      <= '0;
      mark         <= '0;
      alarm_time   <= '0;
      alarm_active <= 1'b0;
    end else begin
      if (rdya) va <= item_valid;
      if (rdyb) vb <= va;
      if (rdyc) vc <= vb;
      if (fire) begin
        counter      <= counter_next;
        mark         <= mark_next;
        alarm_time   <= alarm_time_next;
        alarm_active <= alarm_active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdya) begin
      kind_a <= kind_t'(kind);
      tmo_a  <= alarm_timeout;
      set_a  <= set_c;
    end
    if (rdyb) begin
      cnt_b   <= counter_next;
      mark_b  <= mark_next;
      due_b   <= due_next;
      armed_b <= alarm_active_next;
    end
    if (rdyc) begin
      res_stat.tick_now <= cnt_b;
      res_stat.elapsed  <= cnt_b - mark_b;
      res_stat.due      <= due_b;
      res_stat.armed    <= armed_b;
    end
  end

endmodule
